/* sv/moa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_pkg
// Shared widths, register indexes, defaults and control struct for the
// multichannel oversampling averager.
// ----------------------------------------------------------------------------
package moa_pkg;

    localparam int SAMPLE_W         = 12;
    localparam int SUM_W            = 20;
    localparam int FRAC_W           = 8;
    localparam int AVG_W            = 20;
    localparam int CH_OUT_W         = 4;
    localparam int CC_W             = 5;
    localparam int FS_W             = 9;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 9;
    localparam int FIFO_DEPTH       = 4;
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_FILTER   = 256;

    localparam logic [CC_W-1:0] CC_RESET = CC_W'(4);
    localparam logic [FS_W-1:0] FS_RESET = FS_W'(16);

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE   = CFG_IDX_W'(1);

    typedef struct packed {
        logic [CC_W-1:0] chans;
        logic [FS_W-1:0] sweeps;
        logic            clear;
    } moa_ctrl_t;

endpackage

/* sv/moa_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_ifs
// Valid/ready stream interfaces for sample beats and result beats.
// ----------------------------------------------------------------------------
interface moa_sample_if
    import moa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface moa_result_if
    import moa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CH_OUT_W-1:0] channel;
    logic [AVG_W-1:0]    average;
    logic                last_of_run;

    modport source (output valid, output channel, output average, output last_of_run,
                    input ready);
    modport sink   (input valid, input channel, input average, input last_of_run,
                    output ready);
endinterface

/* sv/moa_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_fifo
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module moa_fifo
    import moa_pkg::*;
#(
    parameter int DATA_W = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);
    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [DATA_W-1:0] slot_reg [FIFO_DEPTH];
    logic [PTR_W:0]    wr_ptr_reg;
    logic [PTR_W:0]    rd_ptr_reg;

    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign full      = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                       (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign pop_data  = slot_reg[rd_ptr_reg[PTR_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg[PTR_W-1:0]] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && not_empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end
endmodule

/* sv/moa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_front
// Accepts sample beats, tags each with its channel and end-of-block flag.
// ----------------------------------------------------------------------------
module moa_front
    import moa_pkg::*;
#(
    parameter int CH_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    moa_sample_if.sink                 samples,
    input  moa_ctrl_t                  ctrl,
    output logic                       push,
    output logic [SAMPLE_W+CH_W:0]     push_data,
    input  logic                       full
);
    localparam int CMP_W = ((CH_W > CC_W) ? CH_W : CC_W) + 1;

    logic [CH_W-1:0] ch_reg;
    logic [FS_W-1:0] sweep_reg;
    logic            last_ch;
    logic            last_sweep;
    logic            accept;

    assign samples.ready = !full;
    assign accept        = samples.valid && !full;
    assign push          = accept;

    assign last_ch    = (CMP_W'(ch_reg) + CMP_W'(1)) >= CMP_W'(ctrl.chans);
    assign last_sweep = ((FS_W + 1)'(sweep_reg) + (FS_W + 1)'(1)) >= (FS_W + 1)'(ctrl.sweeps);
    assign push_data  = {samples.sample, ch_reg, last_ch && last_sweep};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg    <= '0;
            sweep_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            ch_reg    <= '0;
            sweep_reg <= '0;
        end
        else if (accept)
        begin
            if (!last_ch)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            else
            begin
                ch_reg    <= '0;
                sweep_reg <= last_sweep ? '0 : sweep_reg + 1'b1;
            end
        end
    end
endmodule

/* sv/moa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module moa_div
    import moa_pkg::*;
#(
    parameter int N_W = SUM_W + FRAC_W,
    parameter int D_W = FS_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   num_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W:0]     rem_sh;
    logic             fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = num_reg;
    assign rem_sh   = {rem_reg, num_reg[N_W-1]};
    assign fits     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            rem_reg <= '0;
            den_reg <= '0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
            cnt_reg <= CNT_W'(N_W);
        end
        else if (busy)
        begin
            num_reg <= {num_reg[N_W-2:0], fits};
            rem_reg <= fits ? D_W'(rem_sh - {1'b0, den_reg}) : rem_sh[D_W-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

/* sv/moa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_back
// Accumulates queued samples per channel and emits the block averages.
// ----------------------------------------------------------------------------
module moa_back
    import moa_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int CH_W         = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  moa_ctrl_t              ctrl,
    input  logic                   not_empty,
    input  logic [SAMPLE_W+CH_W:0] pop_data,
    output logic                   pop,
    moa_result_if.source           results
);
    localparam int CMP_W = ((CH_W > CC_W) ? CH_W : CC_W) + 1;
    localparam int N_W   = SUM_W + FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_RD,
        ST_DIV,
        ST_WAIT
    } state_t;

    state_t              state_reg;
    logic [SAMPLE_W-1:0] item_sample_reg;
    logic [CH_W-1:0]     item_ch_reg;
    logic                item_end_reg;
    logic [CH_W-1:0]     k_reg;
    logic [MAX_CHANNELS-1:0] vld_reg;
    logic                out_valid_reg;
    logic [CH_OUT_W-1:0] out_channel_reg;
    logic [AVG_W-1:0]    out_average_reg;
    logic                out_last_reg;

    logic [SUM_W-1:0]    sum_mem [MAX_CHANNELS];
    logic [SUM_W-1:0]    rdata_reg;
    logic [CH_W-1:0]     rd_addr;
    logic [SUM_W-1:0]    acc_base;
    logic [SUM_W-1:0]    acc_sum;
    logic [SUM_W-1:0]    emit_sum;
    logic                k_last;
    logic                slot_free;
    logic                div_busy;
    logic [N_W-1:0]      div_q;

    logic [SAMPLE_W-1:0] q_sample;
    logic [CH_W-1:0]     q_ch;
    logic                q_end;

    assign {q_sample, q_ch, q_end} = pop_data;

    assign pop       = (state_reg == ST_IDLE) && not_empty;
    assign rd_addr   = (state_reg == ST_IDLE) ? q_ch : k_reg;
    assign acc_base  = vld_reg[item_ch_reg] ? rdata_reg : '0;
    assign acc_sum   = acc_base + SUM_W'(item_sample_reg);
    assign emit_sum  = vld_reg[k_reg] ? rdata_reg : '0;
    assign k_last    = (CMP_W'(k_reg) + CMP_W'(1)) >= CMP_W'(ctrl.chans);
    assign slot_free = !out_valid_reg || results.ready;

    assign results.valid       = out_valid_reg;
    assign results.channel     = out_channel_reg;
    assign results.average     = out_average_reg;
    assign results.last_of_run = out_last_reg;

    moa_div #(
        .N_W (N_W),
        .D_W (FS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV),
        .dividend ({emit_sum, {FRAC_W{1'b0}}}),
        .divisor  (ctrl.sweeps),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        rdata_reg <= sum_mem[rd_addr];
        if (state_reg == ST_ACC)
        begin
            sum_mem[item_ch_reg] <= acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_sample_reg <= '0;
            item_ch_reg     <= '0;
            item_end_reg    <= 1'b0;
            k_reg           <= '0;
            vld_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_channel_reg <= '0;
            out_average_reg <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctrl.clear)
            begin
                vld_reg <= '0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (not_empty)
                    begin
                        item_sample_reg <= q_sample;
                        item_ch_reg     <= q_ch;
                        item_end_reg    <= q_end;
                        state_reg       <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    vld_reg[item_ch_reg] <= 1'b1;
                    k_reg                <= '0;
                    state_reg            <= item_end_reg ? ST_RD : ST_IDLE;
                end
                ST_RD:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (!div_busy && slot_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_channel_reg <= CH_OUT_W'(k_reg);
                        out_average_reg <= div_q[AVG_W-1:0];
                        out_last_reg    <= k_last;
                        if (k_last)
                        begin
                            vld_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

/* sv/multichannel_oversampling_averager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_oversampling_averager
// Boxcar average of interleaved converter channels, 8 fraction bits.
// ----------------------------------------------------------------------------
// Samples enter on the samples channel as beats, channel 0 first, one sweep
// after another. After channel_count * filter_size beats the block emits one
// result beat per channel in channel order on the results channel; the final
// beat of the block has last_of_run set.
// In the accumulate path a sample beat is read from the sum memory, then
// added and written back; a 4-entry queue lets the input run ahead of that.
// At block end each channel is read, divided by the bit-serial divider (28
// quotient bits) and handed to the output register; the next block is
// accumulated only after every channel has been emitted.
// A stalled receiver holds the output register; once the queue fills the
// input stalls too. Nothing is lost.
// Reset sets channel_count to 4, filter_size to 16 and clears all sums;
// a write to either register also restarts the block. No clearing pass.
// ----------------------------------------------------------------------------
module multichannel_oversampling_averager
    import moa_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_FILTER   = DEF_MAX_FILTER
) (
    input  logic                  clk,
    input  logic                  rst_n,
    moa_sample_if.sink            samples,
    moa_result_if.source          results,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ITEM_W = SAMPLE_W + CH_W + 1;

    logic [CC_W-1:0]   channel_count_reg;
    logic [FS_W-1:0]   filter_size_reg;
    moa_ctrl_t         ctrl;
    logic              push;
    logic              full;
    logic              pop;
    logic              not_empty;
    logic [ITEM_W-1:0] push_data;
    logic [ITEM_W-1:0] pop_data;

    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            ctrl.chans = CC_W'(1);
        end
        else if (32'(channel_count_reg) > MAX_CHANNELS)
        begin
            ctrl.chans = CC_W'(MAX_CHANNELS);
        end
        else
        begin
            ctrl.chans = channel_count_reg;
        end

        if (filter_size_reg == '0)
        begin
            ctrl.sweeps = FS_W'(1);
        end
        else if (32'(filter_size_reg) > MAX_FILTER)
        begin
            ctrl.sweeps = FS_W'(MAX_FILTER);
        end
        else
        begin
            ctrl.sweeps = filter_size_reg;
        end

        ctrl.clear = cfg_wr_en &&
                     ((cfg_index == REG_CHANNEL_COUNT) || (cfg_index == REG_FILTER_SIZE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CC_RESET;
            filter_size_reg   <= FS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CC_W-1:0];
                REG_FILTER_SIZE:   filter_size_reg   <= cfg_data[FS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    moa_front #(
        .CH_W (CH_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .ctrl      (ctrl),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    moa_fifo #(
        .DATA_W (ITEM_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    moa_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .not_empty (not_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .results   (results)
    );
endmodule
